[rtl/core/spf_pkg.sv]
package spf_pkg;

  localparam int MAX_POINTS = 64;
  localparam int FRAC_BITS  = 16;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IVAL_W     = 31;

  localparam logic [IVAL_W-1:0] IVAL_RESET = IVAL_W'(1) << FRAC_BITS;
  localparam logic [1:0]        AXES_RESET = 2'd3;
  localparam logic [1:0]        AXES_2D    = 2'd2;

  // configuration register indexes
  localparam logic [0:0] REG_INTERVAL = 1'b0;
  localparam logic [0:0] REG_AXES     = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_MUL, S_SQ_ACC, S_SQRT_GO, S_SQRT_WAIT, S_CNT_GO, S_CNT_WAIT,
    S_OFFSET, S_PT_MUL, S_PT_GO, S_PT_WAIT, S_EMIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       mul_sq;
    logic       mul_pt;
    logic       acc;
    logic       sqrt_start;
    logic       div_start;
    logic       div_pt;
    logic       take_cnt;
    logic       set_off;
    logic       place;
    logic       step_t;
    logic       emit;
    logic       last;
    logic [1:0] ax;
  } cmd_t;

  typedef struct packed {
    logic             two_d;
    logic             sqrt_done;
    logic             div_done;
    logic             cnt_zero;
    logic [CNT_W-1:0] cnt;
  } sts_t;

endpackage

[rtl/core/segment_point_filler.sv]
// The squares of the direction components are summed (three axes in 3D, two in 2D);
// the square root, the count division and the offset follow before the first point.
// Each point then takes a multiply and one 64-step divider pass per
// coordinate, then an emit, which waits while out_stall holds the output.
// One segment is worked on at a time; the next is taken once all its points
// have been handed to the output register. Reset (synchronous, rst_n low)
// clears the controller and loads the default config.
module segment_point_filler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic               out_last_point,
  output logic               out_count_clipped
);

  spf_pkg::cmd_t cmd;
  spf_pkg::sts_t sts;

  spf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  spf_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_point_x(out_point_x), .out_point_y(out_point_y), .out_point_z(out_point_z),
    .out_last_point(out_last_point), .out_count_clipped(out_count_clipped)
  );

endmodule

[rtl/core/spf_sqrt.sv]
module spf_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] val_r, val_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [34:0] cand, trial;

  always_comb begin
    cand     = {rem_r[32:0], val_r[63:62]};
    trial    = {1'b0, root_r, 2'b01};
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      val_nxt  = value;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = {val_r[61:0], 2'b00};
      if (cand >= trial) begin
        rem_nxt  = cand - trial;
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = cand;
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign done = done_r;

endmodule

[rtl/core/spf_div.sv]
module spf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient,
  output logic        done
);

  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] cand, diff;

  always_comb begin
    cand     = {rem_r, dvd_r[63]};
    diff     = cand - {1'b0, dsr_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // quotient bits shift in behind the dividend
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        dvd_nxt = {dvd_r[62:0], 1'b1};
      end else begin
        rem_nxt = cand[31:0];
        dvd_nxt = {dvd_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient = dvd_r;
  assign done     = done_r;

endmodule

[rtl/core/spf_dp.sv]
module spf_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  spf_pkg::cmd_t            cmd,
  output spf_pkg::sts_t            sts,
  input  logic                     cfg_wr_en,
  input  logic [0:0]               cfg_index,
  input  logic [30:0]              cfg_data,
  input  logic signed [31:0]       in_origin_x,
  input  logic signed [31:0]       in_origin_y,
  input  logic signed [31:0]       in_origin_z,
  input  logic signed [31:0]       in_dir_x,
  input  logic signed [31:0]       in_dir_y,
  input  logic signed [31:0]       in_dir_z,
  output logic signed [31:0]       out_point_x,
  output logic signed [31:0]       out_point_y,
  output logic signed [31:0]       out_point_z,
  output logic                     out_last_point,
  output logic                     out_count_clipped
);

  localparam int CW = spf_pkg::CNT_W;

  logic [spf_pkg::IVAL_W-1:0] ival_cfg_r;
  logic [1:0]                 axes_r;
  logic [31:0]                org_r [3];
  logic [31:0]                dir_r [3];
  logic [63:0]                prod_r, sum_r;
  logic [31:0]                r_r, t_r;
  logic [CW-1:0]              cnt_r;
  logic                       clip_r;
  logic [31:0]                pt_r [3];
  logic [31:0]                px_r, py_r, pz_r;
  logic                       last_r, clipo_r;

  logic [31:0] ival, dsel, dmag, mul_b, org_sel, root, q32;
  logic [63:0] quot, dvd;
  logic [31:0] dsr;
  logic        sqrt_done, div_done;
  logic [37:0] span, diff;
  logic signed [33:0] step, psum;
  logic [31:0] placed;

  assign ival = (ival_cfg_r == '0) ? 32'd1 : {1'b0, ival_cfg_r};
  assign dsel = dir_r[cmd.ax];
  assign dmag = dsel[31] ? (32'd0 - dsel) : dsel;
  assign mul_b = cmd.mul_sq ? dmag : t_r;
  assign dvd   = cmd.div_pt ? prod_r : {32'd0, r_r};
  assign dsr   = cmd.div_pt ? r_r : ival;

  spf_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.sqrt_start), .value(sum_r),
    .root(root), .done(sqrt_done)
  );

  spf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(dvd),
    .divisor(dsr), .quotient(quot), .done(div_done)
  );

  // centre offset: (r - (count - 1) * interval) / 2
  assign span = 38'(cnt_r - CW'(1)) * 38'(ival);
  assign diff = {6'd0, r_r} - span;

  assign org_sel = org_r[cmd.ax];
  assign q32     = quot[31:0];
  assign step    = dsel[31] ? -$signed({2'b00, q32}) : $signed({2'b00, q32});
  assign psum    = $signed({{2{org_sel[31]}}, org_sel}) + step;

  always_comb begin
    if (psum > 34'sh0_7FFF_FFFF) begin
      placed = 32'h7FFF_FFFF;
    end else if (psum < -34'sh0_8000_0000) begin
      placed = 32'h8000_0000;
    end else begin
      placed = psum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ival_cfg_r <= spf_pkg::IVAL_RESET;
      axes_r     <= spf_pkg::AXES_RESET;
      cnt_r      <= '0;
      clip_r     <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_index == spf_pkg::REG_INTERVAL) ival_cfg_r <= cfg_data;
      if (cfg_wr_en && cfg_index == spf_pkg::REG_AXES) axes_r <= cfg_data[1:0];
      if (cmd.take_cnt) begin
        if (quot > 64'(spf_pkg::MAX_POINTS)) begin
          cnt_r  <= CW'(spf_pkg::MAX_POINTS);
          clip_r <= 1'b1;
        end else begin
          cnt_r  <= quot[CW-1:0];
          clip_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      org_r[0] <= in_origin_x;
      org_r[1] <= in_origin_y;
      org_r[2] <= in_origin_z;
      dir_r[0] <= in_dir_x;
      dir_r[1] <= in_dir_y;
      dir_r[2] <= in_dir_z;
      sum_r    <= '0;
      pt_r[2]  <= '0;
    end
    if (cmd.mul_sq || cmd.mul_pt) prod_r <= 64'(dmag) * 64'(mul_b);
    if (cmd.acc) sum_r <= sum_r + prod_r;
    if (sqrt_done) r_r <= root;
    if (cmd.set_off) t_r <= diff[32:1];
    if (cmd.step_t) t_r <= t_r + ival;
    if (cmd.place) pt_r[cmd.ax] <= placed;
    if (cmd.emit) begin
      px_r    <= pt_r[0];
      py_r    <= pt_r[1];
      pz_r    <= pt_r[2];
      last_r  <= cmd.last;
      clipo_r <= clip_r;
    end
  end

  assign sts.two_d     = (axes_r == spf_pkg::AXES_2D);
  assign sts.sqrt_done = sqrt_done;
  assign sts.div_done  = div_done;
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.cnt       = cnt_r;

  assign out_point_x       = px_r;
  assign out_point_y       = py_r;
  assign out_point_z       = pz_r;
  assign out_last_point    = last_r;
  assign out_count_clipped = clipo_r;

endmodule

[rtl/core/spf_ctrl.sv]
module spf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output spf_pkg::cmd_t cmd,
  input  spf_pkg::sts_t sts
);

  localparam int CW = spf_pkg::CNT_W;

  spf_pkg::state_t state_r, state_nxt;
  logic [1:0]      ax_r, ax_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            ov_r, ov_nxt;
  logic            last_ax, slot_free, last_pt;

  assign last_ax   = sts.two_d ? (ax_r == 2'd1) : (ax_r == 2'd2);
  assign slot_free = !ov_r || !out_stall;
  assign last_pt   = (idx_r + CW'(1)) == sts.cnt;

  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.ax    = ax_r;
    cmd.last  = last_pt;
    case (state_r)
      spf_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          ax_nxt    = 2'd0;
          state_nxt = spf_pkg::S_SQ_MUL;
        end
      end
      spf_pkg::S_SQ_MUL: begin
        cmd.mul_sq = 1'b1;
        state_nxt  = spf_pkg::S_SQ_ACC;
      end
      spf_pkg::S_SQ_ACC: begin
        cmd.acc = 1'b1;
        if (last_ax) begin
          state_nxt = spf_pkg::S_SQRT_GO;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = spf_pkg::S_SQ_MUL;
        end
      end
      spf_pkg::S_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = spf_pkg::S_SQRT_WAIT;
      end
      spf_pkg::S_SQRT_WAIT: begin
        if (sts.sqrt_done) state_nxt = spf_pkg::S_CNT_GO;
      end
      spf_pkg::S_CNT_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = spf_pkg::S_CNT_WAIT;
      end
      spf_pkg::S_CNT_WAIT: begin
        if (sts.div_done) begin
          cmd.take_cnt = 1'b1;
          state_nxt    = spf_pkg::S_OFFSET;
        end
      end
      spf_pkg::S_OFFSET: begin
        cmd.set_off = 1'b1;
        ax_nxt      = 2'd0;
        idx_nxt     = '0;
        state_nxt   = sts.cnt_zero ? spf_pkg::S_IDLE : spf_pkg::S_PT_MUL;
      end
      spf_pkg::S_PT_MUL: begin
        cmd.mul_pt = 1'b1;
        state_nxt  = spf_pkg::S_PT_GO;
      end
      spf_pkg::S_PT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_pt    = 1'b1;
        state_nxt     = spf_pkg::S_PT_WAIT;
      end
      spf_pkg::S_PT_WAIT: begin
        cmd.div_pt = 1'b1;
        if (sts.div_done) begin
          cmd.place = 1'b1;
          if (last_ax) begin
            state_nxt = spf_pkg::S_EMIT;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = spf_pkg::S_PT_MUL;
          end
        end
      end
      spf_pkg::S_EMIT: begin
        if (slot_free) begin
          cmd.emit = 1'b1;
          ax_nxt   = 2'd0;
          if (last_pt) begin
            state_nxt = spf_pkg::S_IDLE;
          end else begin
            cmd.step_t = 1'b1;
            idx_nxt    = idx_r + CW'(1);
            state_nxt  = spf_pkg::S_PT_MUL;
          end
        end
      end
      default: state_nxt = spf_pkg::S_IDLE;
    endcase
    ov_nxt = cmd.emit ? 1'b1 : (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spf_pkg::S_IDLE;
      ax_r    <= '0;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_stall  = (state_r != spf_pkg::S_IDLE);
  assign out_valid = ov_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!ov_r || !out_stall)) else $error("item overwrote pending result");

  a_sqrt_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.sqrt_done |-> state_r == spf_pkg::S_SQRT_WAIT) else $error("stray sqrt done");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spf_pkg::S_EMIT |-> idx_r < sts.cnt) else $error("point index past count");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == spf_pkg::S_CNT_WAIT || state_r == spf_pkg::S_PT_WAIT))
    else $error("stray divide done");

endmodule
